/* rtl/core/pwm_enc_pkg.sv */
package pwm_enc_pkg;

    // Field widths of the words on both streams.
    localparam int CAP_W        = 16;
    localparam int DUTY_W       = 16;
    localparam int ANGLE_CODE_W = 16;
    localparam int SPEED_W      = 17;
    localparam int ERR_W        = 2;
    localparam int OP_W         = 2;
    localparam int TIMEOUT_W    = 8;

    // Speed filter accumulator, Q3.
    localparam int ACC_W      = 21;
    localparam int ACC_FRAC   = 3;
    localparam int ROUND_BIAS = 4;

    // Shared divider: 32-bit dividend over a 16-bit divisor.
    localparam int DIVN_W = 32;
    localparam int DIVD_W = 16;

    // Microseconds per minute, the speed scale.
    localparam longint RPM_K   = 60000000;
    localparam int     RPM_K_W = 26;
    localparam int     RPM_POS_MAX = 65535;
    localparam int     RPM_NEG_MAX = 65536;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PER_FLOOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PER_CEIL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;

    localparam logic [DUTY_W-1:0]    RST_DUTY_LOW  = 16'd191;
    localparam logic [DUTY_W-1:0]    RST_DUTY_HIGH = 16'd65348;
    localparam logic [CAP_W-1:0]     RST_PER_FLOOR = 16'd700;
    localparam logic [CAP_W-1:0]     RST_PER_CEIL  = 16'd1500;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT   = 8'd5;

    // Input word kinds.
    typedef enum logic [OP_W-1:0] {
        OP_CAPTURE = 2'd0,
        OP_TICK    = 2'd1,
        OP_OVERCAP = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD     = 2'd2;

    // Stream word layouts.
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = OP_W;

    localparam int OUT_ANGLE_LSB  = 0;
    localparam int OUT_SPEED_LSB  = 16;
    localparam int OUT_ERR_LSB    = 33;
    localparam int OUT_PERIOD_LSB = 35;
    localparam int OUT_PULSE_LSB  = 51;
    localparam int OUT_USED_W     = 67;
    localparam int OUT_DATA_W     = 72;

endpackage

/* rtl/core/pwm_encoder_angle_speed.sv */
// Channel   Dir  Handshake                     Word contents (lowest bits first)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: period_us, pulse_us; tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: angle_code, speed_rpm, error_code,
//                                              last_period_us, last_pulse_us
// cfg       in   i_cfg_wr_en                   i_cfg_index, i_cfg_wdata
//
// A capture word makes up to three 32-step passes through the shared restoring
// divider (duty, angle, speed), with sequencing states between them; the next
// input word is taken only once the sequencer is back in idle. A priming
// capture skips the speed pass, and an empty calibrated span skips the angle pass.
// Ticks, overcapture, rejected captures and idle words need no divider pass.
// Synchronous active-low reset restores the register defaults and the decoder
// state; no clearing pass is needed.
// The result word sits in an output register; the next input word is taken while
// it waits, and the sequencer holds in its last step until that word is taken.
module pwm_encoder_angle_speed
    import pwm_enc_pkg::*;
#(
    parameter int ANGLE_BITS   = 14,
    parameter int FILTER_SHIFT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // period_us[15:0], pulse_us[31:16]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // opcode[1:0]

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // angle_code[15:0], speed_rpm[32:16],
                                                  // error_code[34:33],
                                                  // last_period_us[50:35],
                                                  // last_pulse_us[66:51], zero[71:67]

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AB     = ANGLE_BITS;
    localparam int PROD_W = AB + RPM_K_W;
    localparam int X8_W   = SPEED_W + ACC_FRAC;

    localparam logic signed [AB+1:0] HALF_S  = $signed((AB+2)'(1) << (AB - 1));
    localparam logic signed [AB+1:0] TURN_S  = $signed((AB+2)'(1) << AB);
    localparam logic signed [AB+1:0] NHALF_S = -HALF_S;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_DUTY   = 11'b00000000100,
        S_ANGLE  = 11'b00000001000,
        S_PRIME  = 11'b00000010000,
        S_MUL    = 11'b00000100000,
        S_SPD_GO = 11'b00001000000,
        S_SPEED  = 11'b00010000000,
        S_FILT   = 11'b00100000000,
        S_ROUND  = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [DUTY_W-1:0]    r_duty_low, r_duty_high;
    logic [CAP_W-1:0]     r_per_floor, r_per_ceil;
    logic [TIMEOUT_W-1:0] r_timeout;

    // Latched input word.
    t_opcode          r_op;
    logic [CAP_W-1:0] r_period, r_pulse;

    // Decoder state.
    logic [AB-1:0]              r_angle_now, n_angle_now;
    logic [AB-1:0]              r_angle_before, n_angle_before;
    logic                       r_need_prime, n_need_prime;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [SPEED_W-1:0]  r_speed, n_speed;
    logic [ERR_W-1:0]           r_err, n_err;
    logic [TIMEOUT_W-1:0]       r_stale, n_stale;
    logic                       r_fresh, n_fresh;
    logic [CAP_W-1:0]           r_per_kept, n_per_kept;
    logic [CAP_W-1:0]           r_pul_kept, n_pul_kept;

    // Speed datapath.
    logic [AB-1:0]              r_mag, n_mag;
    logic                       r_neg, n_neg;
    logic [PROD_W-1:0]          r_prod, n_prod;
    logic signed [SPEED_W-1:0]  r_rpm, n_rpm;

    // Output register.
    logic                       r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0]      r_m_data, n_m_data;

    // Shared divider.
    logic              w_div_start;
    logic [DIVN_W-1:0] w_div_num;
    logic [DIVD_W-1:0] w_div_den;
    logic              w_div_done;
    logic [DIVN_W-1:0] w_div_q;

    // Combinational helpers.
    logic                      w_bad;
    logic [DUTY_W:0]           w_duty, w_clamp_lo;
    logic [DUTY_W-1:0]         w_clamp, w_span, w_ofs;
    logic                      w_span_ok;
    logic [AB-1:0]             w_angle;
    logic signed [AB+1:0]      w_delta_raw, w_delta, w_delta_abs;
    logic [TIMEOUT_W-1:0]      w_stale_inc;
    logic signed [SPEED_W-1:0] w_rpm_sat;
    logic signed [X8_W-1:0]    w_x8;
    logic signed [ACC_W:0]     w_diff, w_step;
    logic [ACC_W-1:0]          w_acc_mag, w_rnd;
    logic [SPEED_W-1:0]        w_rnd_s;
    logic [ANGLE_CODE_W-1:0]   w_angle_code;
    logic [SPEED_W-1:0]        w_speed_code;

    pwm_enc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_comb begin
        w_bad = (r_period == '0) || (r_period < r_per_floor) ||
                (r_period > r_per_ceil) || (r_pulse > r_period);

        // Duty is at most one full period, so it fits in 17 bits.
        w_duty     = w_div_q[DUTY_W:0];
        w_clamp_lo = (w_duty < {1'b0, r_duty_low}) ? {1'b0, r_duty_low} : w_duty;
        w_clamp    = (w_clamp_lo > {1'b0, r_duty_high}) ? r_duty_high
                                                        : w_clamp_lo[DUTY_W-1:0];
        w_span_ok  = (r_duty_high > r_duty_low);
        w_span     = r_duty_high - r_duty_low;
        w_ofs      = w_clamp - r_duty_low;

        w_angle = ((w_div_q >> AB) != '0) ? '1 : w_div_q[AB-1:0];

        // Shortest way round the circle.
        w_delta_raw = $signed({2'b00, r_angle_now}) - $signed({2'b00, r_angle_before});
        if (w_delta_raw > HALF_S) begin
            w_delta = w_delta_raw - TURN_S;
        end else if (w_delta_raw < NHALF_S) begin
            w_delta = w_delta_raw + TURN_S;
        end else begin
            w_delta = w_delta_raw;
        end
        w_delta_abs = (w_delta < 0) ? -w_delta : w_delta;

        w_stale_inc = (r_stale != '1) ? r_stale + TIMEOUT_W'(1) : r_stale;

        // Speed is divided as a magnitude, then signed and saturated.
        if (r_neg) begin
            w_rpm_sat = (w_div_q > DIVN_W'(RPM_NEG_MAX))
                      ? $signed(SPEED_W'(RPM_NEG_MAX))
                      : $signed(~w_div_q[SPEED_W-1:0] + SPEED_W'(1));
        end else begin
            w_rpm_sat = (w_div_q > DIVN_W'(RPM_POS_MAX))
                      ? $signed(SPEED_W'(RPM_POS_MAX))
                      : $signed({1'b0, w_div_q[SPEED_W-2:0]});
        end

        w_x8   = $signed({r_rpm, ACC_FRAC'(0)});
        w_diff = (ACC_W+1)'(w_x8) - (ACC_W+1)'(r_acc);
        w_step = w_diff >>> FILTER_SHIFT;

        // Round half away from zero on the magnitude.
        w_acc_mag = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
        w_rnd     = (w_acc_mag + ACC_W'(ROUND_BIAS)) >> ACC_FRAC;
        w_rnd_s   = w_rnd[SPEED_W-1:0];

        w_angle_code = (r_err != ERR_NONE) ? '1 : ANGLE_CODE_W'(r_angle_now);
        w_speed_code = (r_err != ERR_NONE) ? '0 : r_speed;
    end

    always_comb begin
        n_state        = r_state;
        n_angle_now    = r_angle_now;
        n_angle_before = r_angle_before;
        n_need_prime   = r_need_prime;
        n_acc          = r_acc;
        n_speed        = r_speed;
        n_err          = r_err;
        n_stale        = r_stale;
        n_fresh        = r_fresh;
        n_per_kept     = r_per_kept;
        n_pul_kept     = r_pul_kept;
        n_mag          = r_mag;
        n_neg          = r_neg;
        n_prod         = r_prod;
        n_rpm          = r_rpm;
        n_m_valid      = r_m_valid && !m_axis_tready;
        n_m_data       = r_m_data;
        w_div_start    = 1'b0;
        w_div_num      = {r_pulse, DUTY_W'(0)};
        w_div_den      = r_period;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (r_op)
                    OP_CAPTURE: begin
                        if (w_bad) begin
                            n_err        = ERR_BAD;
                            n_acc        = '0;
                            n_speed      = '0;
                            n_need_prime = 1'b1;
                        end else begin
                            n_per_kept  = r_period;
                            n_pul_kept  = r_pulse;
                            n_fresh     = 1'b1;
                            n_err       = ERR_NONE;
                            w_div_start = 1'b1;
                            n_state     = S_DUTY;
                        end
                    end
                    OP_TICK: begin
                        if (r_fresh) begin
                            n_fresh = 1'b0;
                            n_stale = '0;
                        end else begin
                            n_stale = w_stale_inc;
                            if (w_stale_inc >= r_timeout) begin
                                n_err        = ERR_TIMEOUT;
                                n_acc        = '0;
                                n_speed      = '0;
                                n_need_prime = 1'b1;
                            end
                        end
                    end
                    OP_OVERCAP: begin
                        n_err        = ERR_BAD;
                        n_acc        = '0;
                        n_speed      = '0;
                        n_need_prime = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_DUTY: begin
                w_div_num = DIVN_W'(w_ofs) << AB;
                w_div_den = w_span;
                if (w_div_done) begin
                    if (w_span_ok) begin
                        w_div_start = 1'b1;
                        n_state     = S_ANGLE;
                    end else begin
                        n_angle_now = '0;
                        n_state     = S_PRIME;
                    end
                end
            end
            S_ANGLE: begin
                if (w_div_done) begin
                    n_angle_now = w_angle;
                    n_state     = S_PRIME;
                end
            end
            S_PRIME: begin
                if (r_need_prime) begin
                    n_need_prime   = 1'b0;
                    n_angle_before = r_angle_now;
                    n_state        = S_FINISH;
                end else begin
                    n_mag   = w_delta_abs[AB-1:0];
                    n_neg   = (w_delta < 0);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_mag) * PROD_W'(RPM_K);
                n_state = S_SPD_GO;
            end
            S_SPD_GO: begin
                // One turn spans 2^ANGLE_BITS counts, so that part of the divisor
                // is a shift; the remaining division is by the period alone.
                w_div_num   = DIVN_W'(r_prod >> AB);
                w_div_start = 1'b1;
                n_state     = S_SPEED;
            end
            S_SPEED: begin
                if (w_div_done) begin
                    n_rpm   = w_rpm_sat;
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                n_acc   = r_acc + ACC_W'(w_step);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_speed        = r_acc[ACC_W-1] ? $signed(~w_rnd_s + SPEED_W'(1))
                                                : $signed(w_rnd_s);
                n_angle_before = r_angle_now;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = '0;
                    n_m_data[OUT_ANGLE_LSB  +: ANGLE_CODE_W] = w_angle_code;
                    n_m_data[OUT_SPEED_LSB  +: SPEED_W]      = w_speed_code;
                    n_m_data[OUT_ERR_LSB    +: ERR_W]        = r_err;
                    n_m_data[OUT_PERIOD_LSB +: CAP_W]        = r_per_kept;
                    n_m_data[OUT_PULSE_LSB  +: CAP_W]        = r_pul_kept;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_angle_now    <= '0;
            r_angle_before <= '0;
            r_need_prime   <= 1'b1;
            r_acc          <= '0;
            r_speed        <= '0;
            r_err          <= ERR_TIMEOUT;
            r_stale        <= '0;
            r_fresh        <= 1'b1;
            r_per_kept     <= '0;
            r_pul_kept     <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_angle_now    <= n_angle_now;
            r_angle_before <= n_angle_before;
            r_need_prime   <= n_need_prime;
            r_acc          <= n_acc;
            r_speed        <= n_speed;
            r_err          <= n_err;
            r_stale        <= n_stale;
            r_fresh        <= n_fresh;
            r_per_kept     <= n_per_kept;
            r_pul_kept     <= n_pul_kept;
            r_m_valid      <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_rpm    <= n_rpm;
        r_m_data <= n_m_data;
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= t_opcode'(s_axis_tuser[OP_W-1:0]);
            r_period <= s_axis_tdata[CAP_W-1:0];
            r_pulse  <= s_axis_tdata[2*CAP_W-1:CAP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_low  <= RST_DUTY_LOW;
            r_duty_high <= RST_DUTY_HIGH;
            r_per_floor <= RST_PER_FLOOR;
            r_per_ceil  <= RST_PER_CEIL;
            r_timeout   <= RST_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DUTY_LOW:  r_duty_low  <= i_cfg_wdata[DUTY_W-1:0];
                REG_DUTY_HIGH: r_duty_high <= i_cfg_wdata[DUTY_W-1:0];
                REG_PER_FLOOR: r_per_floor <= i_cfg_wdata[CAP_W-1:0];
                REG_PER_CEIL:  r_per_ceil  <= i_cfg_wdata[CAP_W-1:0];
                REG_TIMEOUT:   r_timeout   <= i_cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

/* rtl/core/pwm_enc_div.sv */
module pwm_enc_div
    import pwm_enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_dividend,
    input  logic [DIVD_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVN_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVN_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_div;
    logic [DIVN_W-1:0] r_quo;

    logic [DIVD_W:0]   w_trial;
    logic [DIVD_W:0]   w_diff;
    logic              w_fit;

    // One restoring step: the next dividend bit joins the remainder, which
    // stays below the divisor, so the trial value needs one extra bit only.
    always_comb begin
        w_trial = {r_rem, r_quo[DIVN_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient shifts in where the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVD_W-1:0] : w_trial[DIVD_W-1:0];
            r_quo <= {r_quo[DIVN_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/pwm_enc_chk.sv */
module pwm_enc_chk
    import pwm_enc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [ANGLE_CODE_W-1:0] w_angle;
    logic [SPEED_W-1:0]      w_speed;
    logic [ERR_W-1:0]        w_err;
    logic [CAP_W-1:0]        w_period;
    logic [CAP_W-1:0]        w_pulse;

    assign w_angle  = m_axis_tdata[OUT_ANGLE_LSB  +: ANGLE_CODE_W];
    assign w_speed  = m_axis_tdata[OUT_SPEED_LSB  +: SPEED_W];
    assign w_err    = m_axis_tdata[OUT_ERR_LSB    +: ERR_W];
    assign w_period = m_axis_tdata[OUT_PERIOD_LSB +: CAP_W];
    assign w_pulse  = m_axis_tdata[OUT_PULSE_LSB  +: CAP_W];

    // A word that is not taken stays as it is.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One word is worked on at a time.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in work");

    // An error masks angle and speed.
    a_err_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_err != ERR_NONE) |-> (w_angle == '1) && (w_speed == '0))
        else $error("angle or speed reported during an error");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_err == ERR_NONE) || (w_err == ERR_TIMEOUT) || (w_err == ERR_BAD))
        else $error("undefined error code");

    // No error means a capture was taken, and those have pulse within period.
    a_kept_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_err == ERR_NONE) |-> (w_pulse <= w_period))
        else $error("kept pulse exceeds kept period");

endmodule

bind pwm_encoder_angle_speed pwm_enc_chk u_pwm_enc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
